// ----- rtl/lbd_pkg.sv -----
// ============================================================================
// lbd_pkg: shared types and constants for the least-backlog disk dispatcher
// Holds the configuration register map, reset values and the field layout
// of the result beat.
// ============================================================================
package lbd_pkg;

    // Width of every time register (units of 0.1 ms).
    localparam int TIME_W    = 16;
    // Number of service time registers; disk i uses register i mod SVC_REGS.
    localparam int SVC_REGS  = 4;
    localparam int SVC_SEL_W = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SVC_DISK0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SVC_DISK1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SVC_DISK2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SVC_DISK3 = 3'd4;

    // Register values after reset.
    localparam logic [TIME_W-1:0] TICK_TIME_RST = 16'd394;
    localparam logic [TIME_W-1:0] SVC_DISK0_RST = 16'd771;
    localparam logic [TIME_W-1:0] SVC_DISK1_RST = 16'd1238;
    localparam logic [TIME_W-1:0] SVC_DISK2_RST = 16'd804;
    localparam logic [TIME_W-1:0] SVC_DISK3_RST = 16'd2350;

    // Result field widths.
    localparam int CHOSEN_W = 2;
    localparam int BUSY_W   = 3;
    localparam int JOBS_W   = 32;

    // Stream data widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_FIELD_W = CHOSEN_W + BUSY_W + BUSY_W + JOBS_W + 1;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [TIME_W-1:0]                tick_time;
        logic [SVC_REGS-1:0][TIME_W-1:0]  svc_time;
    } cfg_t;

    // One result beat; the last field declared, chosen_disk, sits in the lowest bits.
    typedef struct packed {
        logic              backlog_saturated;
        logic [JOBS_W-1:0] jobs_total;
        logic [BUSY_W-1:0] peak_busy;
        logic [BUSY_W-1:0] busy_disks;
        logic [CHOSEN_W-1:0] chosen_disk;
    } result_t;

endpackage

// ----- rtl/lbd_cfg_regs.sv -----
// ============================================================================
// lbd_cfg_regs: configuration register file
// Holds the tick time and the four per-disk service times. Writes to an
// index outside the map are dropped.
// ============================================================================
module lbd_cfg_regs
    import lbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [TIME_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    logic [TIME_W-1:0]               tick_time_reg;
    logic [SVC_REGS-1:0][TIME_W-1:0] svc_time_reg;

    // Register writes, decoded by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_time_reg   <= TICK_TIME_RST;
            svc_time_reg[0] <= SVC_DISK0_RST;
            svc_time_reg[1] <= SVC_DISK1_RST;
            svc_time_reg[2] <= SVC_DISK2_RST;
            svc_time_reg[3] <= SVC_DISK3_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TICK_TIME: tick_time_reg   <= wr_data;
                REG_SVC_DISK0: svc_time_reg[0] <= wr_data;
                REG_SVC_DISK1: svc_time_reg[1] <= wr_data;
                REG_SVC_DISK2: svc_time_reg[2] <= wr_data;
                REG_SVC_DISK3: svc_time_reg[3] <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.tick_time = tick_time_reg;
    assign cfg.svc_time  = svc_time_reg;

endmodule

// ----- rtl/lbd_min_tree.sv -----
// ============================================================================
// lbd_min_tree: argmin over the disk backlogs
// A binary compare tree; the left operand wins ties so the lowest disk
// index is chosen among equal backlogs.
// ============================================================================
module lbd_min_tree
    import lbd_pkg::*;
#(
    parameter int NUM_DISKS    = 4,
    parameter int BACKLOG_BITS = 20,
    parameter int IDX_W        = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1
)
(
    input  logic [NUM_DISKS-1:0][BACKLOG_BITS-1:0] backlog,
    output logic [IDX_W-1:0]                       min_idx,
    output logic [BACKLOG_BITS-1:0]                min_val
);

    localparam int LEAVES = 1 << IDX_W;
    localparam int NODES  = 2 * LEAVES - 1;

    logic [BACKLOG_BITS-1:0] node_val [NODES];
    logic [IDX_W-1:0]        node_idx [NODES];

    // Leaves hold the backlogs; unused leaves sit to the right at full
    // scale so they never beat a real disk. Inner nodes keep the smaller
    // child, the left one on a tie.
    always_comb
    begin
        for (int j = 0; j < LEAVES; j++)
        begin
            node_val[LEAVES-1+j] = (j < NUM_DISKS) ? backlog[j] : '1;
            node_idx[LEAVES-1+j] = IDX_W'(j);
        end
        for (int k = LEAVES - 2; k >= 0; k--)
        begin
            if (node_val[2*k+2] < node_val[2*k+1])
            begin
                node_val[k] = node_val[2*k+2];
                node_idx[k] = node_idx[2*k+2];
            end
            else
            begin
                node_val[k] = node_val[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end
        end
    end

    assign min_idx = node_idx[0];
    assign min_val = node_val[0];

endmodule

// ----- rtl/least_backlog_disk_dispatcher.sv -----
// ============================================================================
// least_backlog_disk_dispatcher: join-shortest-queue disk dispatcher
// Each input beat is one scheduler tick. All backlogs drain by the tick
// time; a dispatched job goes to the disk with the smallest backlog.
//
//   Channel    Direction  Fields (lowest bit first)
//   s_axis     in         tdata: dispatch, zero fill to 8 bits
//   m_axis     out        tdata: chosen_disk, busy_disks, peak_busy,
//                                jobs_total, backlog_saturated, zero fill
//   cfg        in         cfg_index selects a register, cfg_data is written
//
// One tick per cycle while m_axis is not stalled: an input register feeds
// the drain, argmin tree, saturating add and counters, which land in the
// result register.
// Reset clears all backlogs and counters and loads the default times.
// A stalled result beat holds its register; the input register keeps
// taking a new beat whenever the result register frees up that cycle.
// ============================================================================
module least_backlog_disk_dispatcher
    import lbd_pkg::*;
#(
    parameter int NUM_DISKS    = 4,
    parameter int BACKLOG_BITS = 20
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Tick stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] dispatch
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] chosen_disk, [4:2] busy_disks, [7:5] peak_busy,
    // [39:8] jobs_total, [40] backlog_saturated
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration writes.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [TIME_W-1:0]      cfg_data
);

    localparam int IDX_W = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;
    localparam int CNT_W = $clog2(NUM_DISKS + 1);

    cfg_t cfg;

    logic in_valid_reg;
    logic in_dispatch_reg;
    logic out_valid_reg;
    result_t out_data_reg;
    logic advance;

    logic [NUM_DISKS-1:0][BACKLOG_BITS-1:0] backlog_reg;
    logic [NUM_DISKS-1:0][BACKLOG_BITS-1:0] backlog_next;
    logic [NUM_DISKS-1:0][BACKLOG_BITS-1:0] drained;
    logic [JOBS_W-1:0] jobs_reg;
    logic [JOBS_W-1:0] jobs_next;
    logic [BUSY_W-1:0] peak_reg;
    logic [BUSY_W-1:0] peak_next;

    logic [IDX_W-1:0]        pick;
    logic [BACKLOG_BITS-1:0] min_val;
    logic [IDX_W+1:0]        pick_ext;
    logic [BACKLOG_BITS:0]   sum;
    logic                    clipped;
    logic [BACKLOG_BITS-1:0] added;
    logic [CNT_W-1:0]        busy;
    logic [CNT_W+2:0]        busy_ext;
    logic [BUSY_W-1:0]       busy3;
    result_t                 result;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    lbd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: a tick moves on when the result register is free or drains.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_dispatch_reg <= s_axis_tdata[0];
        end
    end

    // Drain every backlog by the tick time, flooring at zero.
    always_comb
    begin
        for (int i = 0; i < NUM_DISKS; i++)
        begin
            if (backlog_reg[i] <= BACKLOG_BITS'(cfg.tick_time))
            begin
                drained[i] = '0;
            end
            else
            begin
                drained[i] = backlog_reg[i] - BACKLOG_BITS'(cfg.tick_time);
            end
        end
    end

    // Least drained backlog, lowest index on a tie.
    lbd_min_tree #(
        .NUM_DISKS    (NUM_DISKS),
        .BACKLOG_BITS (BACKLOG_BITS),
        .IDX_W        (IDX_W)
    ) u_min_tree (
        .backlog (drained),
        .min_idx (pick),
        .min_val (min_val)
    );

    // Add the chosen disk's service time, saturating at full scale.
    assign pick_ext = {2'b00, pick};
    assign sum      = {1'b0, min_val}
                    + (BACKLOG_BITS + 1)'(cfg.svc_time[pick_ext[SVC_SEL_W-1:0]]);
    assign clipped  = sum[BACKLOG_BITS];
    assign added    = clipped ? '1 : sum[BACKLOG_BITS-1:0];

    // Next backlogs and busy disk count.
    always_comb
    begin
        busy = '0;
        for (int i = 0; i < NUM_DISKS; i++)
        begin
            if (in_dispatch_reg && (pick == IDX_W'(i)))
            begin
                backlog_next[i] = added;
            end
            else
            begin
                backlog_next[i] = drained[i];
            end
            if (backlog_next[i] != '0)
            begin
                busy = busy + CNT_W'(1);
            end
        end
    end

    assign busy_ext  = {3'b000, busy};
    assign busy3     = busy_ext[BUSY_W-1:0];
    assign peak_next = (busy3 > peak_reg) ? busy3 : peak_reg;
    assign jobs_next = (in_dispatch_reg && (jobs_reg != '1)) ? jobs_reg + JOBS_W'(1)
                                                             : jobs_reg;

    // Assemble the result beat.
    always_comb
    begin
        result.chosen_disk       = in_dispatch_reg ? pick_ext[CHOSEN_W-1:0] : '0;
        result.busy_disks        = busy3;
        result.peak_busy         = peak_next;
        result.jobs_total        = jobs_next;
        result.backlog_saturated = in_dispatch_reg & clipped;
    end

    // Dispatcher state, updated once per tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlog_reg <= '0;
            jobs_reg    <= '0;
            peak_reg    <= '0;
        end
        else if (advance)
        begin
            backlog_reg <= backlog_next;
            jobs_reg    <= jobs_next;
            peak_reg    <= peak_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_data_reg};

endmodule
